@@ sv/rep_pkg.sv @@
// ----------------------------------------------------------------------------
// rep_pkg: shared types and constants for the ring ether pattern filter
// Payload structs, action codes and the per-column cell types.
// ----------------------------------------------------------------------------
package rep_pkg;

  localparam int unsigned ROW_W  = 64;
  localparam int unsigned DEPTH  = 4;
  localparam int unsigned FILL_W = 3;

  // Window is full once four rows are in.
  localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

  localparam logic ACT_PUSH    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic             action;
    logic [ROW_W-1:0] new_row;
  } rep_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic [ROW_W-1:0] shown;
  } rep_out_t;

  // One ring position across the window, bit 0 = oldest row.
  typedef logic [DEPTH-1:0] rep_col_t;

  typedef struct packed {
    logic shift;  // a row is pushed this cycle
    logic scan;   // a row is pushed into a full window, tile search applies
  } rep_ctrl_t;

endpackage

@@ sv/rep_cell.sv @@
// ----------------------------------------------------------------------------
// rep_cell: one ring position of the filter
// Holds four row bits and four hide bits, detects the tile anchored here
// and folds in the tiles anchored at the three positions behind it.
// ----------------------------------------------------------------------------
module rep_cell
  import rep_pkg::*;
(
  input  logic      clk_i,
  input  rep_ctrl_t ctrl_i,
  input  logic      new_bit_i,
  input  rep_col_t  nbr1_i,    // columns at +1, +2, +3
  input  rep_col_t  nbr2_i,
  input  rep_col_t  nbr3_i,
  input  logic      hit_m1_i,  // tile hits anchored at -1, -2, -3
  input  logic      hit_m2_i,
  input  logic      hit_m3_i,
  output rep_col_t  col_o,
  output logic      hit_o,
  output logic      cell_o,
  output logic      shown_o
);

  rep_col_t row_q, row_d;
  rep_col_t mask_q, mask_d;
  logic     cov4, cov2;

  // Tile, oldest row first: 1111 / 1000 / 1001 / 10
  assign hit_o = ctrl_i.scan
               & row_q[0] &  nbr1_i[0] &  nbr2_i[0] &  nbr3_i[0]
               & row_q[1] & ~nbr1_i[1] & ~nbr2_i[1] & ~nbr3_i[1]
               & row_q[2] & ~nbr1_i[2] & ~nbr2_i[2] &  nbr3_i[2]
               & row_q[3] & ~nbr1_i[3];

  assign cov4 = hit_o | hit_m1_i | hit_m2_i | hit_m3_i;
  assign cov2 = hit_o | hit_m1_i;

  assign col_o   = row_q;
  assign cell_o  = row_q[0];
  assign shown_o = ~(mask_q[0] | cov4);

  always_comb begin
    row_d  = row_q;
    mask_d = mask_q;
    if (ctrl_i.shift) begin
      row_d     = {new_bit_i, row_q[DEPTH-1:1]};
      mask_d[0] = mask_q[1] | cov4;
      mask_d[1] = mask_q[2] | cov4;
      mask_d[2] = mask_q[3] | cov2;
      mask_d[3] = 1'b0;
    end
  end

  // Payload only: the fill phase shifts clean masks through the window.
  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    mask_q <= mask_d;
  end

endmodule

@@ sv/rep_out_buf.sv @@
// ----------------------------------------------------------------------------
// rep_out_buf: two-entry result buffer
// Decouples the output stall from the input side; full only when two
// results wait.
// ----------------------------------------------------------------------------
module rep_out_buf
  import rep_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  rep_out_t wr_data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rep_out_t out_data_o
);

  rep_out_t   slot_q [2];
  logic       rd_ptr_q, rd_ptr_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic [1:0] count_q, count_d;
  logic       rd;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign rd          = out_valid_o & ~out_stall_i;

  always_comb begin
    rd_ptr_d = rd_ptr_q ^ rd;
    wr_ptr_d = wr_ptr_q ^ wr_i;
    count_d  = count_q;
    if (wr_i && !rd) begin
      count_d = count_q + 2'd1;
    end else if (rd && !wr_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ sv/ring_ether_pattern_filter.sv @@
// ----------------------------------------------------------------------------
// ring_ether_pattern_filter: space-time tile filter for a ring automaton
// Keeps the last four generations, hides cells covered by a fixed tile and
// emits the oldest generation with its visible mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per
//   generation row, or a restart when action is set. A restart empties the
//   window; the next four pushes only refill it and yield no result.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one transfer
//   per push once the window is full, carrying the oldest row and the
//   cells not covered by any tile. Bits at or above CELLS read as zero.
// Timing:
//   One row per cycle sustained while the receiver keeps up. The ring is
//   matched and the masks updated by a row of CELLS cells in the cycle the
//   row is taken; with the buffer empty, the result is presented the cycle
//   after the input transfer. A two-entry result buffer sits before the
//   output; in_stall_o rises only when both entries wait. A full-rate
//   stream keeps one entry in use, so receiver stalls also stall the input.
// Reset:
//   rst_ni clears the fill count and empties the result buffer. Window
//   contents are don't-care until refilled.
// ----------------------------------------------------------------------------
module ring_ether_pattern_filter
  import rep_pkg::*;
#(
  parameter int unsigned CELLS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rep_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rep_out_t out_data_o
);

  localparam logic [ROW_W-1:0] RowMask = (CELLS >= ROW_W) ? {ROW_W{1'b1}}
                                       : ((ROW_W'(1) << CELLS) - ROW_W'(1));

  logic              buf_full;
  logic              in_xfer;
  logic              push;
  logic              restart;
  logic [FILL_W-1:0] fill_q, fill_d;
  rep_ctrl_t         ctrl;

  rep_col_t          col   [CELLS];
  logic [CELLS-1:0]  hit;
  logic [CELLS-1:0]  cells_row;
  logic [CELLS-1:0]  shown_row;
  rep_out_t          result;

  assign in_stall_o = buf_full;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign push       = in_xfer & (in_data_i.action == ACT_PUSH);
  assign restart    = in_xfer & (in_data_i.action == ACT_RESTART);

  assign ctrl.shift = push;
  assign ctrl.scan  = push & (fill_q == FILL_FULL);

  // Fill count saturates at four; restart starts over.
  always_comb begin
    fill_d = fill_q;
    if (restart) begin
      fill_d = '0;
    end else if (push && fill_q != FILL_FULL) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Ring of cells: each sees the three columns ahead and the three hits
  // behind, all indices wrapping around the ring.
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    rep_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .new_bit_i (in_data_i.new_row[k]),
      .nbr1_i    (col[(k + 1) % CELLS]),
      .nbr2_i    (col[(k + 2) % CELLS]),
      .nbr3_i    (col[(k + 3) % CELLS]),
      .hit_m1_i  (hit[(k + CELLS - 1) % CELLS]),
      .hit_m2_i  (hit[(k + CELLS - 2) % CELLS]),
      .hit_m3_i  (hit[(k + CELLS - 3) % CELLS]),
      .col_o     (col[k]),
      .hit_o     (hit[k]),
      .cell_o    (cells_row[k]),
      .shown_o   (shown_row[k])
    );
  end

  assign result.cells = ROW_W'(cells_row);
  assign result.shown = ROW_W'(shown_row);

  rep_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (ctrl.scan),
    .wr_data_i   (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> fill_q == '0)
    else $error("fill count not cleared by restart");

  a_fill_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && fill_q != FILL_FULL) |=> fill_q == $past(fill_q) + FILL_W'(1))
    else $error("fill count did not advance on push");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("fill count past full window");

  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_ring_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.cells | out_data_o.shown) & ~RowMask) == '0)
    else $error("result bits set beyond ring size");

endmodule
